// ===== hw/rtl/pawm_pkg.sv =====
// Shared types, widths, codes and a helper function of the piecewise affine warp map.
// No dependencies; imported by piecewise_affine_warp_map.
`default_nettype none

package pawm_pkg;

  // Default values of the top-level parameters
  localparam int DEF_MAX_TRIANGLES = 128;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_MAX_DIM       = 1024;

  // Field widths
  localparam int Q_W      = 32;   // signed fixed-point word
  localparam int TRI_W    = 7;    // triangle index
  localparam int POS_W    = 10;   // pixel column / row
  localparam int CMD_W    = 2;
  localparam int NUM_OPS  = 6;
  localparam int ROW_W    = NUM_OPS * Q_W;
  localparam int WIDE_W   = 64;   // width of values handed to the saturation helper

  // Input tdata layout, lowest bit first
  localparam int OFF_OP     = TRI_W;
  localparam int OFF_COL    = OFF_OP + ROW_W;
  localparam int OFF_ROW    = OFF_COL + POS_W;
  localparam int OFF_INSIDE = OFF_ROW + POS_W;
  localparam int IN_DATA_W  = ((OFF_INSIDE + 1 + 7) / 8) * 8;

  localparam int OUT_DATA_W = 2 * Q_W;

  // Command codes carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_WEIGHTS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VERTS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [Q_W-1:0] q_t;

  // Clamp a wide signed value to the signed Q word range
  function automatic q_t sat_q(input logic signed [WIDE_W-1:0] v);
    q_t res;
    if (v[WIDE_W-1:Q_W-1] == '0 || v[WIDE_W-1:Q_W-1] == '1) begin
      res = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = Q_MIN;
    end else begin
      res = Q_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/piecewise_affine_warp_map.sv =====
// Piecewise affine warp map generator: weight/coefficient tables and a five-stage
// multiply pipeline. Depends on pawm_pkg.
//
// Usage:
//   in_*  : command stream. in_tuser carries the command (load weights, load source
//           vertices, pixel). Weight loads are written at acceptance; vertex loads
//           travel the pipeline and write the triangle's six coefficients at its end;
//           pixels travel the pipeline and produce one transaction on out_*.
//   out_* : one transaction per pixel: map_x / map_y in out_tdata, covered in out_tuser.
//   cfg_* : writes of origin_x / origin_y, always ready; issue them only while idle.
// Path: an accepted pixel passes stages 1 to 4, then the output register, to out_tvalid.
// Throughput: one transaction per cycle while out_tready is high; the limit is the
//   coefficient table: a pixel is held off while a vertex load is still in the
//   pipeline, ahead of its coefficient table write.
// Reset: rst_n (synchronous) empties the pipeline and the output register and clears
//   both origins; the tables are not cleared and must be loaded before use.
// Stall: when out_tready is low the result holds in the output register; stages
//   behind it keep advancing into empty slots, so up to four more pixels are
//   taken before in_tready falls. Nothing is dropped or repeated.
`default_nettype none

module piecewise_affine_warp_map #(
  parameter int MAX_TRIANGLES = pawm_pkg::DEF_MAX_TRIANGLES,
  parameter int FRAC_BITS     = pawm_pkg::DEF_FRAC_BITS,
  parameter int MAX_DIM       = pawm_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // triangle, operand_0..operand_5, col, row, inside_req, zero pad
  input  logic [pawm_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd
  input  logic [pawm_pkg::CMD_W-1:0]        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // map_x, map_y
  output logic [pawm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // covered
  output logic [0:0]                        out_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pawm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pawm_pkg::Q_W-1:0]          cfg_data
);

  import pawm_pkg::*;

  localparam int AW      = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int PROD_W  = 2 * Q_W;
  localparam int RW      = PROD_W - FRAC_BITS;   // rounded product width
  localparam int SW      = RW + 2;               // three-term sum width
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] NEG_ONE = Q_W'(-(longint'(1) << FRAC_BITS));
  localparam logic [POS_W-1:0] DIM_LAST = POS_W'(MAX_DIM - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  q_t origin_x_r, origin_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  logic [TRI_W-1:0]      in_tri;
  logic [TRI_W+AW-1:0]   in_tri_ext;
  logic [AW-1:0]         in_addr;
  logic                  in_tri_ok;
  logic [POS_W-1:0]      in_col, in_row, in_col_c, in_row_c;
  logic                  in_inside;
  logic                  in_acc;
  q_t                    in_op [NUM_OPS];

  assign in_tri     = in_tdata[TRI_W-1:0];
  assign in_tri_ext = (TRI_W + AW)'(in_tri);
  assign in_addr    = in_tri_ext[AW-1:0];
  assign in_tri_ok  = 32'(in_tri) < 32'(MAX_TRIANGLES);
  assign in_col     = in_tdata[OFF_COL +: POS_W];
  assign in_row     = in_tdata[OFF_ROW +: POS_W];
  assign in_inside  = in_tdata[OFF_INSIDE];
  assign in_col_c   = (32'(in_col) >= 32'(MAX_DIM)) ? DIM_LAST : in_col;
  assign in_row_c   = (32'(in_row) >= 32'(MAX_DIM)) ? DIM_LAST : in_row;

  always_comb begin
    for (int i = 0; i < NUM_OPS; i++) begin
      in_op[i] = in_tdata[OFF_OP + i*Q_W +: Q_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when empty or when the next one advances
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic pix1_r, pix2_r, pix3_r, pix4_r;
  logic ready1, ready2, ready3, ready4;
  logic vert_busy;
  logic out_valid_r;

  assign ready4 = !v4_r || !pix4_r || !out_valid_r || out_tready;
  assign ready3 = !v3_r || ready4;
  assign ready2 = !v2_r || ready3;
  assign ready1 = !v1_r || ready2;

  // vertex loads still ahead of the coefficient table write
  assign vert_busy = (v1_r && !pix1_r) || (v2_r && !pix2_r) ||
                     (v3_r && !pix3_r) || (v4_r && !pix4_r);

  // hold a pixel back until its coefficients can have been written
  assign in_tready = ready1 && !(in_tuser == CMD_PIXEL && vert_busy);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_acc && (in_tuser == CMD_VERTS || in_tuser == CMD_PIXEL);
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: tables, read at acceptance
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] wt_mem [MAX_TRIANGLES];
  logic [ROW_W-1:0] cf_mem [MAX_TRIANGLES];
  logic [ROW_W-1:0] wt_rd_r, cf_rd_r;
  logic [ROW_W-1:0] coef_row_nxt;
  logic [AW-1:0]    addr1_r, addr2_r, addr3_r, addr4_r;
  logic             ok1_r;
  logic             hit2_r, hit3_r, hit4_r;
  logic             inside1_r;
  logic [POS_W-1:0] col1_r, row1_r;
  q_t               op1_r [NUM_OPS];

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == CMD_WEIGHTS && in_tri_ok) begin
      wt_mem[in_addr] <= in_tdata[OFF_OP +: ROW_W];
    end
    if (ready1) begin
      wt_rd_r <= wt_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && !pix4_r && hit4_r) begin
      cf_mem[addr4_r] <= coef_row_nxt;
    end
    if (ready1) begin
      cf_rd_r <= cf_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      pix1_r    <= in_tuser == CMD_PIXEL;
      ok1_r     <= in_tri_ok;
      addr1_r   <= in_addr;
      col1_r    <= in_col_c;
      row1_r    <= in_row_c;
      inside1_r <= in_inside;
      for (int i = 0; i < NUM_OPS; i++) op1_r[i] <= in_op[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: vertex differences or pixel position, operand selection
  // ---------------------------------------------------------------------------
  q_t dx1, dx2, dy1, dy2, xi, yi;
  q_t m_nxt [4];
  q_t m2_r  [4];
  q_t tbl_nxt [NUM_OPS];
  q_t tbl2_r  [NUM_OPS];
  q_t base_x_nxt, base_y_nxt;
  q_t base_x2_r, base_y2_r, base_x3_r, base_y3_r, base_x4_r, base_y4_r;

  always_comb begin
    dx1 = sat_q(WIDE_W'(op1_r[1]) - WIDE_W'(op1_r[0]));
    dx2 = sat_q(WIDE_W'(op1_r[2]) - WIDE_W'(op1_r[0]));
    dy1 = sat_q(WIDE_W'(op1_r[4]) - WIDE_W'(op1_r[3]));
    dy2 = sat_q(WIDE_W'(op1_r[5]) - WIDE_W'(op1_r[3]));
    xi  = sat_q(signed'(WIDE_W'(col1_r) << FRAC_BITS) + WIDE_W'(origin_x_r));
    yi  = sat_q(signed'(WIDE_W'(row1_r) << FRAC_BITS) + WIDE_W'(origin_y_r));
    m_nxt[0] = pix1_r ? xi : dx1;
    m_nxt[1] = pix1_r ? yi : dx2;
    m_nxt[2] = pix1_r ? xi : dy1;
    m_nxt[3] = pix1_r ? yi : dy2;
    for (int i = 0; i < NUM_OPS; i++) begin
      tbl_nxt[i] = pix1_r ? cf_rd_r[i*Q_W +: Q_W] : wt_rd_r[i*Q_W +: Q_W];
    end
    base_x_nxt = pix1_r ? cf_rd_r[0 +: Q_W]   : op1_r[0];
    base_y_nxt = pix1_r ? cf_rd_r[3*Q_W +: Q_W] : op1_r[3];
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      pix2_r    <= pix1_r;
      addr2_r   <= addr1_r;
      // pixels need the inside flag, vertex loads only the range check
      hit2_r    <= ok1_r && (inside1_r || !pix1_r);
      base_x2_r <= base_x_nxt;
      base_y2_r <= base_y_nxt;
      for (int i = 0; i < 4; i++) m2_r[i] <= m_nxt[i];
      for (int i = 0; i < NUM_OPS; i++) tbl2_r[i] <= tbl_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: twelve 32x32 products, two per coefficient
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_nxt [NUM_OPS][2];
  logic signed [PROD_W-1:0] prod3_r  [NUM_OPS][2];

  always_comb begin
    q_t la, lb, ra, rb;
    for (int k = 0; k < NUM_OPS; k++) begin
      la = (k < 3) ? m2_r[0] : m2_r[2];
      lb = (k < 3) ? m2_r[1] : m2_r[3];
      ra = tbl2_r[(k < 3) ? k : k - 3];
      rb = tbl2_r[(k < 3) ? k + 3 : k];
      // pixels use the map_x and map_y lanes with the linear terms of the row
      if (pix2_r && (k == 0 || k == 3)) begin
        ra = tbl2_r[(k < 3) ? 1 : 4];
        rb = tbl2_r[(k < 3) ? 2 : 5];
      end
      prod_nxt[k][0] = PROD_W'(la) * PROD_W'(ra);
      prod_nxt[k][1] = PROD_W'(lb) * PROD_W'(rb);
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      pix3_r    <= pix2_r;
      addr3_r   <= addr2_r;
      hit3_r    <= hit2_r;
      base_x3_r <= base_x2_r;
      base_y3_r <= base_y2_r;
      for (int k = 0; k < NUM_OPS; k++) begin
        prod3_r[k][0] <= prod_nxt[k][0];
        prod3_r[k][1] <= prod_nxt[k][1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round each product, ties upward
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] rnd_nxt [NUM_OPS][2];
  logic signed [RW-1:0] rnd4_r  [NUM_OPS][2];

  always_comb begin
    logic signed [PROD_W-1:0] t;
    for (int k = 0; k < NUM_OPS; k++) begin
      for (int j = 0; j < 2; j++) begin
        t = prod3_r[k][j] + HALF;
        rnd_nxt[k][j] = t[PROD_W-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      pix4_r    <= pix3_r;
      addr4_r   <= addr3_r;
      hit4_r    <= hit3_r;
      base_x4_r <= base_x3_r;
      base_y4_r <= base_y3_r;
      for (int k = 0; k < NUM_OPS; k++) begin
        rnd4_r[k][0] <= rnd_nxt[k][0];
        rnd4_r[k][1] <= rnd_nxt[k][1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final sums: coefficient row for vertex loads, map result for pixels
  // ---------------------------------------------------------------------------
  q_t coef_nxt [NUM_OPS];

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [Q_W-1:0] base;
    for (int k = 0; k < NUM_OPS; k++) begin
      base = (k == 0) ? base_x4_r : ((k == 3) ? base_y4_r : '0);
      sum  = SW'(base) + SW'(rnd4_r[k][0]) + SW'(rnd4_r[k][1]);
      coef_nxt[k] = sat_q(WIDE_W'(sum));
      coef_row_nxt[k*Q_W +: Q_W] = coef_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  q_t   map_x_r, map_y_r, map_x_nxt, map_y_nxt;
  logic covered_r;

  assign map_x_nxt = hit4_r ? coef_nxt[0] : NEG_ONE;
  assign map_y_nxt = hit4_r ? coef_nxt[3] : NEG_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= v4_r && pix4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      map_x_r   <= map_x_nxt;
      map_y_r   <= map_y_nxt;
      covered_r <= hit4_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {map_y_r, map_x_r};
  assign out_tuser[0] = covered_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a result appears only after a pixel sat in the last stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v4_r && pix4_r))
    else $error("result without a pixel in the last stage");

  // the coefficient write never overlaps a pixel taking its table read
  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !pix4_r) |-> !(in_tvalid && in_tready && in_tuser == CMD_PIXEL))
    else $error("pixel accepted during coefficient write");

  // a pixel in the last stage waits while the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && pix4_r && out_tvalid && !out_tready) |=> (v4_r && pix4_r))
    else $error("pixel lost while output stalled");

  // an uncovered result carries -1.0 in both coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |->
      (out_tdata[Q_W-1:0] == NEG_ONE && out_tdata[2*Q_W-1:Q_W] == NEG_ONE))
    else $error("uncovered result is not -1.0");

endmodule

`default_nettype wire
